### sv/stb_pkg.sv
`default_nettype none

package stb_pkg;

  localparam int unsigned NUM_TIMERS_DEF = 16;
  localparam int unsigned TICK_WIDTH_DEF = 32;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned FIRED_W = 16;
  localparam int unsigned FIRED_IDX_W = $clog2(FIRED_W);

  localparam int unsigned RESERVED_TIMER_ID = 0;
  localparam int unsigned FIRST_TIMER_ID = RESERVED_TIMER_ID + 1;

  localparam logic [2:0] REQ_TICK  = 3'd0;
  localparam logic [2:0] REQ_ALLOC = 3'd1;
  localparam logic [2:0] REQ_START = 3'd2;
  localparam logic [2:0] REQ_STOP  = 3'd3;
  localparam logic [2:0] REQ_QUERY = 3'd4;

  localparam logic MODE_SINGLE = 1'b0;

  typedef enum logic [2:0] {
    OP_TICK,
    OP_ALLOC,
    OP_START,
    OP_STOP,
    OP_QUERY,
    OP_REJECT
  } cmd_op_e;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [3:0]  timer_id;
    logic [31:0] period_ticks;
    logic        timer_mode;
    logic        notify_enable;
  } in_beat_t;

  typedef struct packed {
    logic        accepted;
    logic [3:0]  alloc_id;
    logic        expired_flag;
    logic [15:0] fired_mask;
  } out_beat_t;

  typedef struct packed {
    cmd_op_e     op;
    logic [3:0]  timer_id;
    logic [31:0] period_ticks;
    logic        timer_mode;
    logic        notify_enable;
  } cmd_t;

endpackage

`default_nettype wire

### sv/software_timer_bank.sv
// channel   | handshake              | payload
// request   | push / full            | req_i (in_beat_t)
// result    | empty / pop            | res_o (out_beat_t)
//
// the front classifies one request beat per cycle while its two-entry queue has room
// a tick walks the period and count memories one timer a cycle, up to the allocated count
// allocate, start, stop, query and refused requests need no walk; the back registers their result when it takes them
// reset is asynchronous and needs no clearing pass
// a result waiting on pop stalls the back only; the front keeps filling the queue
`default_nettype none

module software_timer_bank #(
  parameter int unsigned NUM_TIMERS = stb_pkg::NUM_TIMERS_DEF,
  parameter int unsigned TICK_WIDTH = stb_pkg::TICK_WIDTH_DEF
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                push,
  output logic               full,
  input  stb_pkg::in_beat_t  req_i,
  output logic               empty,
  input  wire                pop,
  output stb_pkg::out_beat_t res_o
);
  import stb_pkg::*;

  localparam int unsigned CNT_W = $clog2(NUM_TIMERS + 1);

  typedef struct packed {
    logic [CNT_W-1:0] cnt;
    cmd_t             cmd;
  } q_entry_t;

  cmd_t             front_cmd;
  logic [CNT_W-1:0] front_cnt;
  logic             q_push, q_full, q_pop, q_empty;
  q_entry_t         q_in, q_out;

  assign q_in.cnt = front_cnt;
  assign q_in.cmd = front_cmd;

  stb_front #(
    .NUM_TIMERS(NUM_TIMERS)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (req_i),
    .push_i   (push),
    .full_o   (full),
    .cmd_o    (front_cmd),
    .cnt_o    (front_cnt),
    .q_push_o (q_push),
    .q_full_i (q_full)
  );

  stb_fifo #(
    .entry_t(q_entry_t),
    .DEPTH  (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .data_i (q_in),
    .full_o (q_full),
    .pop_i  (q_pop),
    .data_o (q_out),
    .empty_o(q_empty)
  );

  stb_back #(
    .NUM_TIMERS(NUM_TIMERS),
    .TICK_WIDTH(TICK_WIDTH)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (q_out.cmd),
    .cnt_i      (q_out.cnt),
    .cmd_empty_i(q_empty),
    .cmd_pop_o  (q_pop),
    .res_o      (res_o),
    .res_empty_o(empty),
    .res_pop_i  (pop)
  );

endmodule

`default_nettype wire

### sv/stb_front.sv
`default_nettype none

module stb_front #(
  parameter int unsigned NUM_TIMERS = stb_pkg::NUM_TIMERS_DEF,
  localparam int unsigned CNT_W = $clog2(NUM_TIMERS + 1)
) (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  stb_pkg::in_beat_t req_i,
  input  wire              push_i,
  output logic             full_o,
  output stb_pkg::cmd_t    cmd_o,
  output logic [CNT_W-1:0] cnt_o,
  output logic             q_push_o,
  input  wire              q_full_i
);
  import stb_pkg::*;

  localparam int unsigned EXT_W = (CNT_W > 4) ? CNT_W : 4;

  logic [CNT_W-1:0] alloc_q, alloc_d;
  logic [EXT_W-1:0] id_ext;

  assign full_o   = q_full_i;
  assign q_push_o = push_i && !q_full_i;
  assign id_ext   = EXT_W'(req_i.timer_id);
  assign cnt_o    = alloc_q;

  always_comb begin
    cmd_o.op            = OP_REJECT;
    cmd_o.timer_id      = req_i.timer_id;
    cmd_o.period_ticks  = req_i.period_ticks;
    cmd_o.timer_mode    = req_i.timer_mode;
    cmd_o.notify_enable = req_i.notify_enable;
    alloc_d             = alloc_q;
    unique case (req_i.req_type)
      REQ_TICK: begin
        cmd_o.op = OP_TICK;
      end
      REQ_ALLOC: begin
        if (alloc_q < CNT_W'(NUM_TIMERS)) begin
          cmd_o.op = OP_ALLOC;
          alloc_d  = alloc_q + CNT_W'(1);
        end
      end
      REQ_START: begin
        if (id_ext < EXT_W'(alloc_q)) begin
          cmd_o.op = OP_START;
        end
      end
      REQ_STOP: begin
        if (id_ext < EXT_W'(NUM_TIMERS)) begin
          cmd_o.op = OP_STOP;
        end
      end
      REQ_QUERY: begin
        if (id_ext < EXT_W'(NUM_TIMERS)) begin
          cmd_o.op = OP_QUERY;
        end
      end
      default: begin
        cmd_o.op = OP_REJECT;
      end
    endcase
  end

  // allocated count, timer zero reserved
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alloc_q <= CNT_W'(FIRST_TIMER_ID);
    end else if (q_push_o) begin
      alloc_q <= alloc_d;
    end
  end

endmodule

`default_nettype wire

### sv/stb_fifo.sv
`default_nettype none

module stb_fifo #(
  parameter type         entry_t = logic,
  parameter int unsigned DEPTH   = stb_pkg::QUEUE_DEPTH
) (
  input  wire    clk_i,
  input  wire    rst_ni,
  input  wire    push_i,
  input  entry_t data_i,
  output logic   full_o,
  input  wire    pop_i,
  output entry_t data_o,
  output logic   empty_o
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned FILL_W = $clog2(DEPTH + 1);

  entry_t           slots_q [DEPTH];
  logic [PTR_W-1:0] wr_q, rd_q;
  logic [FILL_W-1:0] fill_q;
  logic             do_push, do_pop;

  assign full_o  = (fill_q == FILL_W'(DEPTH));
  assign empty_o = (fill_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = slots_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= '0;
      rd_q   <= '0;
      fill_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        fill_q <= fill_q + FILL_W'(1);
      end else if (do_pop && !do_push) begin
        fill_q <= fill_q - FILL_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

### sv/stb_back.sv
`default_nettype none

module stb_back #(
  parameter int unsigned NUM_TIMERS = stb_pkg::NUM_TIMERS_DEF,
  parameter int unsigned TICK_WIDTH = stb_pkg::TICK_WIDTH_DEF,
  localparam int unsigned CNT_W = $clog2(NUM_TIMERS + 1)
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  stb_pkg::cmd_t     cmd_i,
  input  wire [CNT_W-1:0]   cnt_i,
  input  wire               cmd_empty_i,
  output logic              cmd_pop_o,
  output stb_pkg::out_beat_t res_o,
  output logic              res_empty_o,
  input  wire               res_pop_i
);
  import stb_pkg::*;

  localparam int unsigned IDX_W = $clog2(NUM_TIMERS);
  localparam int unsigned CMP_W = IDX_W + 5;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_WALK = 2'b10
  } back_state_e;

  back_state_e state_q, state_d;

  logic [TICK_WIDTH-1:0] period_mem [NUM_TIMERS];
  logic [TICK_WIDTH-1:0] count_mem [NUM_TIMERS];
  logic [TICK_WIDTH-1:0] per_rd_q, cnt_rd_q;

  logic [NUM_TIMERS-1:0] running_q, running_d;
  logic [NUM_TIMERS-1:0] expired_q, expired_d;
  logic [NUM_TIMERS-1:0] mode_q, mode_d;
  logic [NUM_TIMERS-1:0] notify_q, notify_d;

  logic [CNT_W-1:0]   k_q, k_d, limit_q, limit_d;
  logic               s1_q, s1_d;
  logic [IDX_W-1:0]   e_q, e_d;
  logic [FIRED_W-1:0] fired_q, fired_d;
  out_beat_t          res_q, res_d;
  logic               res_valid_q, res_valid_d;

  logic                  slot_free, take, start_fire, more;
  logic [IDX_W-1:0]      idx;
  logic                  rd_en;
  logic [IDX_W-1:0]      rd_addr;
  logic                  cnt_we;
  logic [IDX_W-1:0]      cnt_waddr;
  logic [TICK_WIDTH-1:0] cnt_wdata, cnt_inc;
  logic                  per_we;
  logic [TICK_WIDTH-1:0] per_wdata;

  assign slot_free   = !res_valid_q || res_pop_i;
  assign take        = (state_q == ST_IDLE) && !cmd_empty_i && slot_free;
  assign cmd_pop_o   = take;
  assign idx         = IDX_W'(cmd_i.timer_id);
  assign cnt_inc     = cnt_rd_q + TICK_WIDTH'(1);
  assign more        = (k_q < limit_q);
  assign res_o       = res_q;
  assign res_empty_o = !res_valid_q;
  assign rd_addr     = k_q[IDX_W-1:0];
  assign per_wdata   = TICK_WIDTH'(cmd_i.period_ticks);

  always_comb begin
    state_d     = state_q;
    running_d   = running_q;
    expired_d   = expired_q;
    mode_d      = mode_q;
    notify_d    = notify_q;
    k_d         = k_q;
    limit_d     = limit_q;
    s1_d        = 1'b0;
    e_d         = e_q;
    fired_d     = fired_q;
    res_d       = res_q;
    res_valid_d = res_valid_q && !res_pop_i;
    rd_en       = 1'b0;
    cnt_we      = 1'b0;
    cnt_waddr   = e_q;
    cnt_wdata   = '0;
    per_we      = 1'b0;
    start_fire  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (take) begin
          res_d = '0;
          unique case (cmd_i.op)
            OP_TICK: begin
              k_d     = '0;
              limit_d = cnt_i;
              fired_d = '0;
              state_d = ST_WALK;
            end
            OP_ALLOC: begin
              running_d[IDX_W'(cnt_i)] = 1'b0;
              res_d.accepted = 1'b1;
              res_d.alloc_id = 4'(cnt_i);
              res_valid_d    = 1'b1;
            end
            OP_START: begin
              notify_d[idx]  = cmd_i.notify_enable;
              expired_d[idx] = 1'b0;
              mode_d[idx]    = cmd_i.timer_mode;
              running_d[idx] = 1'b1;
              cnt_we         = 1'b1;
              cnt_waddr      = idx;
              per_we         = 1'b1;
              start_fire     = 1'b1;
              res_d.accepted = 1'b1;
              res_valid_d    = 1'b1;
            end
            OP_STOP: begin
              running_d[idx] = 1'b0;
              expired_d[idx] = 1'b1;
              res_d.accepted = 1'b1;
              res_valid_d    = 1'b1;
            end
            OP_QUERY: begin
              res_d.accepted     = 1'b1;
              res_d.expired_flag = expired_q[idx];
              res_valid_d        = 1'b1;
            end
            default: begin
              res_valid_d = 1'b1;
            end
          endcase
        end
      end
      ST_WALK: begin
        // read one timer a cycle, evaluate it the cycle after
        if (more) begin
          rd_en = 1'b1;
          k_d   = k_q + CNT_W'(1);
          s1_d  = 1'b1;
          e_d   = k_q[IDX_W-1:0];
        end
        if (s1_q && running_q[e_q]) begin
          cnt_we    = 1'b1;
          cnt_wdata = cnt_inc;
          if (cnt_inc >= per_rd_q) begin
            cnt_wdata = '0;
            if (notify_q[e_q] && (CMP_W'(e_q) < CMP_W'(FIRED_W))) begin
              fired_d[FIRED_IDX_W'(e_q)] = 1'b1;
            end
            if (mode_q[e_q] == MODE_SINGLE) begin
              running_d[e_q] = 1'b0;
              expired_d[e_q] = 1'b1;
            end
          end
        end
        if (!more && !s1_q) begin
          res_d            = '0;
          res_d.accepted   = 1'b1;
          res_d.fired_mask = fired_q;
          res_valid_d      = 1'b1;
          state_d          = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      running_q   <= '0;
      expired_q   <= '0;
      mode_q      <= '0;
      notify_q    <= '0;
      k_q         <= '0;
      limit_q     <= '0;
      s1_q        <= 1'b0;
      e_q         <= '0;
      fired_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      running_q   <= running_d;
      expired_q   <= expired_d;
      mode_q      <= mode_d;
      notify_q    <= notify_d;
      k_q         <= k_d;
      limit_q     <= limit_d;
      s1_q        <= s1_d;
      e_q         <= e_d;
      fired_q     <= fired_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  // period and count memories, one write and one registered read each
  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      per_rd_q <= period_mem[rd_addr];
      cnt_rd_q <= count_mem[rd_addr];
    end
    if (cnt_we) begin
      count_mem[cnt_waddr] <= cnt_wdata;
    end
    if (per_we) begin
      period_mem[idx] <= per_wdata;
    end
  end

`ifndef NO_ASSERTIONS
  a_walk_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALK) |-> !res_valid_q)
    else $error("result pending during tick walk");

  a_rw_apart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rd_en && cnt_we) |-> (rd_addr != cnt_waddr))
    else $error("count read and write collide");

  a_start_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_fire |=> running_q[$past(idx)])
    else $error("started timer not running");

  a_walk_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALK) |-> (k_q <= limit_q))
    else $error("walk index beyond allocated count");
`endif

endmodule

`default_nettype wire
